/* rtl/tls_sni_extractor_defines.svh */
// assertion helpers shared by the rtl files
`ifndef TLS_SNI_EXTRACTOR_DEFINES_SVH
`define TLS_SNI_EXTRACTOR_DEFINES_SVH

// same-cycle implication, checked on every clock edge out of reset
`define TSNI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tls sni extractor check failed");

// next-cycle implication
`define TSNI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tls sni extractor check failed");

`endif

/* rtl/tsni_pkg.sv */
package tsni_pkg;

  // widths of the byte counters and the beat fields
  localparam int unsigned COUNT_BITS = 25;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned HS_LEN_W   = 24;
  localparam int unsigned SUM_W      = ((COUNT_BITS > HS_LEN_W) ? COUNT_BITS : HS_LEN_W) + 1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SUM_W-1:0]      count_sum_t;

  localparam count_t COUNT_MAX = '1;

  // protocol constants
  localparam logic [BYTE_W-1:0] REC_TYPE_HANDSHAKE = 8'h16;
  localparam logic [BYTE_W-1:0] VER_MAJOR          = 8'h03;
  localparam logic [BYTE_W-1:0] HS_CLIENT_HELLO    = 8'h01;
  localparam logic [BYTE_W-1:0] NAME_TYPE_HOST     = 8'h00;
  localparam logic [LEN_W-1:0]  EXT_SERVER_NAME    = 16'h0000;
  localparam int unsigned       REC_HDR_SKIP       = 3;
  localparam int unsigned       HS_HDR_END         = 9;
  localparam int unsigned       FIXED_LEN          = 34;
  localparam int unsigned       MIN_SNI_EXT_LEN    = 2;
  localparam int unsigned       EXT_HDR_LEN        = 4;
  localparam int unsigned       ENT_HDR_LEN        = 3;

  // clamp a widened sum to the counter range
  function automatic count_t sat_count(input count_sum_t v);
    count_t r;
    if (v > count_sum_t'(COUNT_MAX)) begin
      r = COUNT_MAX;
    end else begin
      r = v[COUNT_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/tsni_in_if.sv */
interface tsni_in_if import tsni_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/tsni_out_if.sv */
interface tsni_out_if import tsni_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] name_byte;
  logic              name_valid;
  logic              done_res;
  logic              found;
  logic [LEN_W-1:0]  sni_len;

  modport source (output valid, output name_byte, output name_valid, output done_res,
                  output found, output sni_len, input ready);
  modport sink   (input valid, input name_byte, input name_valid, input done_res,
                  input found, input sni_len, output ready);
endinterface

/* rtl/tls_sni_extractor.sv */
// TLS ClientHello server name extractor. Record bytes come in one beat per byte, with
// last_byte set on the final one. The parser checks the record and handshake headers,
// skips the fixed fields, session id, cipher suites and compression methods, walks the
// extensions to the first host name entry of a server name list and forwards each name
// byte as a result beat (name_valid = 1). The beat for the final byte carries done_res
// and, when a complete non-empty name was seen and the record covers the declared
// handshake length and the server name extension, found = 1 and the name length; with
// found = 0 the consumer drops any name bytes already passed on. Bytes that yield no
// result produce no beat. Throughput is one byte per clock while no waiting result beat
// holds the parser; a byte is taken into the input register on acceptance and moves on to
// the result register when the parser advances, which a waiting result beat can hold
// off. The parser returns to its reset state after every final byte, ready for the next
// record.
`include "tls_sni_extractor_defines.svh"

module tls_sni_extractor import tsni_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsni_in_if.sink    in_i,
  tsni_out_if.source out_o
);

  // parser phases
  localparam logic [4:0] PH_TYPE        = 5'd0;
  localparam logic [4:0] PH_VER         = 5'd1;
  localparam logic [4:0] PH_RECHDR      = 5'd2;
  localparam logic [4:0] PH_HSTYPE      = 5'd3;
  localparam logic [4:0] PH_HSLEN       = 5'd4;
  localparam logic [4:0] PH_FIXED       = 5'd5;
  localparam logic [4:0] PH_SIDLEN      = 5'd6;
  localparam logic [4:0] PH_SKIP_SID    = 5'd7;
  localparam logic [4:0] PH_CS_HI       = 5'd8;
  localparam logic [4:0] PH_CS_LO       = 5'd9;
  localparam logic [4:0] PH_SKIP_CS     = 5'd10;
  localparam logic [4:0] PH_COMP_LEN    = 5'd11;
  localparam logic [4:0] PH_SKIP_COMP   = 5'd12;
  localparam logic [4:0] PH_EXTS_HI     = 5'd13;
  localparam logic [4:0] PH_EXTS_LO     = 5'd14;
  localparam logic [4:0] PH_EXT_TYPE_HI = 5'd15;
  localparam logic [4:0] PH_EXT_TYPE_LO = 5'd16;
  localparam logic [4:0] PH_EXT_LEN_HI  = 5'd17;
  localparam logic [4:0] PH_EXT_LEN_LO  = 5'd18;
  localparam logic [4:0] PH_SKIP_EXT    = 5'd19;
  localparam logic [4:0] PH_LIST_HI     = 5'd20;
  localparam logic [4:0] PH_LIST_LO     = 5'd21;
  localparam logic [4:0] PH_ENT_TYPE    = 5'd22;
  localparam logic [4:0] PH_ENT_LEN_HI  = 5'd23;
  localparam logic [4:0] PH_ENT_LEN_LO  = 5'd24;
  localparam logic [4:0] PH_SKIP_ENT    = 5'd25;
  localparam logic [4:0] PH_NAME        = 5'd26;
  localparam logic [4:0] PH_FOUND       = 5'd27;
  localparam logic [4:0] PH_FAIL        = 5'd28;

  function automatic logic [LEN_W-1:0] dec16(input logic [LEN_W-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic logic [HS_LEN_W-1:0] dec24(input logic [HS_LEN_W-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  // next phase when an extension header is due
  function automatic logic [4:0] ext_hdr(input logic [LEN_W-1:0] ebr);
    return (ebr < LEN_W'(EXT_HDR_LEN)) ? PH_FAIL : PH_EXT_TYPE_HI;
  endfunction

  // next phase when a list entry header is due
  function automatic logic [4:0] entry_hdr(input logic [LEN_W-1:0] slr,
                                           input logic [LEN_W-1:0] er,
                                           input logic [LEN_W-1:0] ebr);
    logic [4:0] r;
    if (slr < LEN_W'(ENT_HDR_LEN)) begin
      r = (er == '0) ? ext_hdr(ebr) : PH_SKIP_EXT;
    end else begin
      r = PH_ENT_TYPE;
    end
    return r;
  endfunction

  // input register
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;

  // parser state
  logic [4:0]          phase_q, phase_d;
  count_t              bc_q, bc_d;
  logic [HS_LEN_W-1:0] skip_q, skip_d;
  logic [LEN_W-1:0]    ebr_q, ebr_d;
  logic [LEN_W-1:0]    er_q, er_d;
  logic [LEN_W-1:0]    slr_q, slr_d;
  logic [BYTE_W-1:0]   hold_q, hold_d;
  logic                sn_q, sn_d;
  logic [LEN_W-1:0]    nrem_q, nrem_d;
  logic [LEN_W-1:0]    ntot_q, ntot_d;
  count_t              req_q, req_d;

  // result register
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_name_valid_q;
  logic              out_done_q;
  logic              out_found_q;
  logic [LEN_W-1:0]  out_len_q;

  // working values
  count_t              bc_inc;
  logic [LEN_W-1:0]    word;
  logic [HS_LEN_W-1:0] hs_len;
  logic [HS_LEN_W-1:0] skip_dec;
  logic [LEN_W-1:0]    ebr_dec, er_dec, slr_dec, nrem_dec, slr_new;
  count_t              ext_end;
  logic                nvalid;
  logic                found;
  logic                emit;
  logic                adv;

  // handshake: a byte moves on when it yields no beat or the result register frees up
  assign emit       = (phase_q == PH_NAME) || in_last_q;
  assign adv        = in_valid_q && (!emit || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // parser next state
  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    ebr_d   = ebr_q;
    er_d    = er_q;
    slr_d   = slr_q;
    hold_d  = hold_q;
    sn_d    = sn_q;
    nrem_d  = nrem_q;
    ntot_d  = ntot_q;
    req_d   = req_q;
    nvalid  = 1'b0;
    slr_new = '0;
    ext_end = '0;

    bc_inc   = (bc_q == COUNT_MAX) ? bc_q : bc_q + 1'b1;
    bc_d     = bc_inc;
    word     = {hold_q, in_byte_q};
    hs_len   = {skip_q[HS_LEN_W-BYTE_W-1:0], in_byte_q};
    skip_dec = dec24(skip_q);
    ebr_dec  = dec16(ebr_q);
    er_dec   = dec16(er_q);
    slr_dec  = dec16(slr_q);
    nrem_dec = dec16(nrem_q);

    unique case (phase_q)
      PH_TYPE: begin
        phase_d = (in_byte_q != REC_TYPE_HANDSHAKE) ? PH_FAIL : PH_VER;
      end
      PH_VER: begin
        if (in_byte_q != VER_MAJOR) begin
          phase_d = PH_FAIL;
        end else begin
          skip_d  = HS_LEN_W'(REC_HDR_SKIP);
          phase_d = PH_RECHDR;
        end
      end
      PH_RECHDR: begin
        skip_d = skip_dec;
        if (skip_dec == '0) phase_d = PH_HSTYPE;
      end
      PH_HSTYPE: begin
        if (in_byte_q != HS_CLIENT_HELLO) begin
          phase_d = PH_FAIL;
        end else begin
          skip_d  = '0;
          phase_d = PH_HSLEN;
        end
      end
      PH_HSLEN: begin
        skip_d = hs_len;
        if (bc_inc >= COUNT_BITS'(HS_HDR_END)) begin
          req_d   = sat_count(count_sum_t'(HS_HDR_END) + count_sum_t'(hs_len));
          skip_d  = HS_LEN_W'(FIXED_LEN);
          phase_d = PH_FIXED;
        end
      end
      PH_FIXED: begin
        skip_d = skip_dec;
        if (skip_dec == '0) phase_d = PH_SIDLEN;
      end
      PH_SIDLEN: begin
        skip_d  = HS_LEN_W'(in_byte_q);
        phase_d = (in_byte_q != '0) ? PH_SKIP_SID : PH_CS_HI;
      end
      PH_SKIP_SID: begin
        skip_d = skip_dec;
        if (skip_dec == '0) phase_d = PH_CS_HI;
      end
      PH_CS_HI: begin
        hold_d  = in_byte_q;
        phase_d = PH_CS_LO;
      end
      PH_CS_LO: begin
        skip_d  = HS_LEN_W'(word);
        phase_d = (word != '0) ? PH_SKIP_CS : PH_COMP_LEN;
      end
      PH_SKIP_CS: begin
        skip_d = skip_dec;
        if (skip_dec == '0) phase_d = PH_COMP_LEN;
      end
      PH_COMP_LEN: begin
        skip_d  = HS_LEN_W'(in_byte_q);
        phase_d = (in_byte_q != '0) ? PH_SKIP_COMP : PH_EXTS_HI;
      end
      PH_SKIP_COMP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) phase_d = PH_EXTS_HI;
      end
      PH_EXTS_HI: begin
        hold_d  = in_byte_q;
        phase_d = PH_EXTS_LO;
      end
      PH_EXTS_LO: begin
        ebr_d   = word;
        phase_d = ext_hdr(word);
      end
      PH_EXT_TYPE_HI: begin
        hold_d  = in_byte_q;
        ebr_d   = ebr_dec;
        phase_d = PH_EXT_TYPE_LO;
      end
      PH_EXT_TYPE_LO: begin
        sn_d    = (word == EXT_SERVER_NAME);
        ebr_d   = ebr_dec;
        phase_d = PH_EXT_LEN_HI;
      end
      PH_EXT_LEN_HI: begin
        hold_d  = in_byte_q;
        ebr_d   = ebr_dec;
        phase_d = PH_EXT_LEN_LO;
      end
      PH_EXT_LEN_LO: begin
        ebr_d = ebr_dec;
        if (word > ebr_dec) begin
          phase_d = PH_FAIL;
        end else begin
          ebr_d = ebr_dec - word;
          er_d  = word;
          if (sn_q && (word >= LEN_W'(MIN_SNI_EXT_LEN))) begin
            // the record must reach the end of this extension
            ext_end = sat_count(count_sum_t'(bc_inc) + count_sum_t'(word));
            if (ext_end > req_q) req_d = ext_end;
            phase_d = PH_LIST_HI;
          end else if (word == '0) begin
            phase_d = ext_hdr(ebr_dec);
          end else begin
            phase_d = PH_SKIP_EXT;
          end
        end
      end
      PH_SKIP_EXT: begin
        er_d = er_dec;
        if (er_dec == '0) phase_d = ext_hdr(ebr_q);
      end
      PH_LIST_HI: begin
        hold_d  = in_byte_q;
        er_d    = er_dec;
        phase_d = PH_LIST_LO;
      end
      PH_LIST_LO: begin
        // list length is cut to what the extension still holds
        er_d    = er_dec;
        slr_new = (word < er_dec) ? word : er_dec;
        slr_d   = slr_new;
        phase_d = entry_hdr(slr_new, er_dec, ebr_q);
      end
      PH_ENT_TYPE: begin
        sn_d    = (in_byte_q == NAME_TYPE_HOST);
        er_d    = er_dec;
        slr_d   = slr_dec;
        phase_d = PH_ENT_LEN_HI;
      end
      PH_ENT_LEN_HI: begin
        hold_d  = in_byte_q;
        er_d    = er_dec;
        slr_d   = slr_dec;
        phase_d = PH_ENT_LEN_LO;
      end
      PH_ENT_LEN_LO: begin
        er_d  = er_dec;
        slr_d = slr_dec;
        if (word > slr_dec) begin
          phase_d = PH_FAIL;
        end else if (sn_q) begin
          if (word == '0) begin
            phase_d = PH_FAIL;
          end else begin
            nrem_d  = word;
            ntot_d  = word;
            phase_d = PH_NAME;
          end
        end else if (word == '0) begin
          phase_d = entry_hdr(slr_dec, er_dec, ebr_q);
        end else begin
          nrem_d  = word;
          phase_d = PH_SKIP_ENT;
        end
      end
      PH_SKIP_ENT: begin
        er_d   = er_dec;
        slr_d  = slr_dec;
        nrem_d = nrem_dec;
        if (nrem_dec == '0) phase_d = entry_hdr(slr_dec, er_dec, ebr_q);
      end
      PH_NAME: begin
        nvalid = 1'b1;
        nrem_d = nrem_dec;
        if (nrem_dec == '0) phase_d = PH_FOUND;
      end
      default: begin
      end
    endcase

    found = (phase_d == PH_FOUND) && (bc_inc >= req_d);

    // end of record: back to the reset state
    if (in_last_q) begin
      phase_d = PH_TYPE;
      bc_d    = '0;
      skip_d  = '0;
      ebr_d   = '0;
      er_d    = '0;
      slr_d   = '0;
      hold_d  = '0;
      sn_d    = 1'b0;
      nrem_d  = '0;
      ntot_d  = '0;
      req_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      bc_q    <= '0;
      skip_q  <= '0;
      ebr_q   <= '0;
      er_q    <= '0;
      slr_q   <= '0;
      hold_q  <= '0;
      sn_q    <= 1'b0;
      nrem_q  <= '0;
      ntot_q  <= '0;
      req_q   <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      skip_q  <= skip_d;
      ebr_q   <= ebr_d;
      er_q    <= er_d;
      slr_q   <= slr_d;
      hold_q  <= hold_d;
      sn_q    <= sn_d;
      nrem_q  <= nrem_d;
      ntot_q  <= ntot_d;
      req_q   <= req_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // found only follows a completed name, so the stored total is the length
  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_byte_q       <= nvalid ? in_byte_q : '0;
      out_name_valid_q <= nvalid;
      out_done_q       <= in_last_q;
      out_found_q      <= in_last_q && found;
      out_len_q        <= (in_last_q && found) ? ntot_q : '0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.name_byte  = out_byte_q;
  assign out_o.name_valid = out_name_valid_q;
  assign out_o.done_res   = out_done_q;
  assign out_o.found      = out_found_q;
  assign out_o.sni_len    = out_len_q;

  // checks
  `TSNI_ASSERT_IMP(a_beat_has_content, out_valid_q, out_name_valid_q || out_done_q)
  `TSNI_ASSERT_IMP(a_found_has_length, out_valid_q && out_found_q, out_done_q && out_len_q != '0)
  `TSNI_ASSERT_NEXT(a_held_byte_kept, in_valid_q && !adv, in_valid_q && $stable(in_byte_q))
  `TSNI_ASSERT_IMP(a_name_count_live, phase_q == PH_NAME, nrem_q != '0)
  `TSNI_ASSERT_NEXT(a_done_clears, adv && in_last_q, phase_q == PH_TYPE && bc_q == '0)

endmodule

/* tb/sv/tsni_checker.sv */
module tsni_checker import tsni_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsni_in_if          in_mon_i,
  tsni_out_if         out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned beats_checked_o,
  output int unsigned names_found_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 100;

  // position of the parser inside the record
  typedef enum logic [4:0] {
    PS_REC_TYPE, PS_VERSION, PS_REC_HDR, PS_HS_TYPE, PS_HS_LEN, PS_FIXED,
    PS_SID_LEN, PS_SKIP_SID, PS_CS_HI, PS_CS_LO, PS_SKIP_CS, PS_COMP_LEN,
    PS_SKIP_COMP, PS_EXTS_HI, PS_EXTS_LO, PS_EXT_TYPE_HI, PS_EXT_TYPE_LO,
    PS_EXT_LEN_HI, PS_EXT_LEN_LO, PS_SKIP_EXT, PS_LIST_HI, PS_LIST_LO,
    PS_ENT_TYPE, PS_ENT_LEN_HI, PS_ENT_LEN_LO, PS_SKIP_ENT, PS_NAME,
    PS_FOUND, PS_FAIL
  } parse_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] name_byte;
    logic              name_valid;
    logic              done_res;
    logic              found;
    logic [LEN_W-1:0]  sni_len;
  } hello_beat_t;

  // shadow parser state
  parse_state_e      parse_state;
  count_t            seen_count;
  logic [23:0]       skip_left;
  logic [16:0]       ext_block_left;
  logic [15:0]       ext_left;
  logic [15:0]       list_left;
  logic [7:0]        hi_hold;
  logic              sni_flag;
  logic [15:0]       name_left;
  logic [15:0]       name_len_total;
  count_t            need_end;
  logic              found_flag;
  logic              failed_flag;

  hello_beat_t       name_beats_due[$];
  hello_beat_t       want_beat;
  int unsigned       mismatch_count = 0;
  int unsigned       beats_checked  = 0;
  int unsigned       names_found    = 0;

  function automatic count_t clamp_count(input logic [32:0] v);
    if (v > 33'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return v[COUNT_BITS-1:0];
  endfunction

  function automatic logic [23:0] count_down(input logic [23:0] v);
    return (v == '0) ? '0 : v - 24'd1;
  endfunction

  function automatic void reset_parser();
    parse_state    = PS_REC_TYPE;
    seen_count     = '0;
    skip_left      = '0;
    ext_block_left = '0;
    ext_left       = '0;
    list_left      = '0;
    hi_hold        = '0;
    sni_flag       = 1'b0;
    name_left      = '0;
    name_len_total = '0;
    need_end       = '0;
    found_flag     = 1'b0;
    failed_flag    = 1'b0;
  endfunction

  function automatic void mark_failed();
    failed_flag = 1'b1;
    parse_state = PS_FAIL;
  endfunction

  // an extension header needs four bytes of the block
  function automatic void next_ext_header();
    if (ext_block_left < EXT_HDR_LEN) begin
      mark_failed();
    end else begin
      parse_state = PS_EXT_TYPE_HI;
    end
  endfunction

  // a list entry header needs three bytes of the list
  function automatic void next_entry_header();
    if (list_left < ENT_HDR_LEN) begin
      if (ext_left == '0) begin
        next_ext_header();
      end else begin
        parse_state = PS_SKIP_EXT;
      end
    end else begin
      parse_state = PS_ENT_TYPE;
    end
  endfunction

  function automatic void step_in_list();
    ext_left  = 16'(count_down(24'(ext_left)));
    list_left = 16'(count_down(24'(list_left)));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  // advance the shadow parser by one record byte and queue the beat it causes
  task automatic parse_hello_byte(input logic [7:0] b, input logic is_last);
    logic        nvalid;
    logic [16:0] v;
    count_t      ext_end;
    hello_beat_t beat;
    nvalid     = 1'b0;
    seen_count = clamp_count(33'(seen_count) + 33'd1);
    case (parse_state)
      PS_REC_TYPE: begin
        if (b != REC_TYPE_HANDSHAKE) mark_failed();
        else parse_state = PS_VERSION;
      end
      PS_VERSION: begin
        if (b != VER_MAJOR) begin
          mark_failed();
        end else begin
          skip_left   = 24'(REC_HDR_SKIP);
          parse_state = PS_REC_HDR;
        end
      end
      PS_REC_HDR: begin
        skip_left = count_down(skip_left);
        if (skip_left == '0) parse_state = PS_HS_TYPE;
      end
      PS_HS_TYPE: begin
        if (b != HS_CLIENT_HELLO) begin
          mark_failed();
        end else begin
          skip_left   = '0;
          parse_state = PS_HS_LEN;
        end
      end
      PS_HS_LEN: begin
        skip_left = {skip_left[15:0], b};
        if (seen_count >= HS_HDR_END) begin
          need_end    = clamp_count(33'(HS_HDR_END) + 33'(skip_left));
          skip_left   = 24'(FIXED_LEN);
          parse_state = PS_FIXED;
        end
      end
      PS_FIXED: begin
        skip_left = count_down(skip_left);
        if (skip_left == '0) parse_state = PS_SID_LEN;
      end
      PS_SID_LEN: begin
        skip_left   = 24'(b);
        parse_state = (b != '0) ? PS_SKIP_SID : PS_CS_HI;
      end
      PS_SKIP_SID: begin
        skip_left = count_down(skip_left);
        if (skip_left == '0) parse_state = PS_CS_HI;
      end
      PS_CS_HI: begin
        hi_hold     = b;
        parse_state = PS_CS_LO;
      end
      PS_CS_LO: begin
        skip_left   = {8'h00, hi_hold, b};
        parse_state = (skip_left != '0) ? PS_SKIP_CS : PS_COMP_LEN;
      end
      PS_SKIP_CS: begin
        skip_left = count_down(skip_left);
        if (skip_left == '0) parse_state = PS_COMP_LEN;
      end
      PS_COMP_LEN: begin
        skip_left   = 24'(b);
        parse_state = (b != '0) ? PS_SKIP_COMP : PS_EXTS_HI;
      end
      PS_SKIP_COMP: begin
        skip_left = count_down(skip_left);
        if (skip_left == '0) parse_state = PS_EXTS_HI;
      end
      PS_EXTS_HI: begin
        hi_hold     = b;
        parse_state = PS_EXTS_LO;
      end
      PS_EXTS_LO: begin
        ext_block_left = {1'b0, hi_hold, b};
        next_ext_header();
      end
      PS_EXT_TYPE_HI: begin
        hi_hold        = b;
        ext_block_left = 17'(count_down(24'(ext_block_left)));
        parse_state    = PS_EXT_TYPE_LO;
      end
      PS_EXT_TYPE_LO: begin
        sni_flag       = ({hi_hold, b} == EXT_SERVER_NAME);
        ext_block_left = 17'(count_down(24'(ext_block_left)));
        parse_state    = PS_EXT_LEN_HI;
      end
      PS_EXT_LEN_HI: begin
        hi_hold        = b;
        ext_block_left = 17'(count_down(24'(ext_block_left)));
        parse_state    = PS_EXT_LEN_LO;
      end
      PS_EXT_LEN_LO: begin
        ext_block_left = 17'(count_down(24'(ext_block_left)));
        v = {1'b0, hi_hold, b};
        if (v > ext_block_left) begin
          mark_failed();
        end else begin
          ext_block_left = ext_block_left - v;
          ext_left       = v[15:0];
          if (sni_flag && v >= MIN_SNI_EXT_LEN) begin
            // the record has to hold the whole server name extension
            ext_end = clamp_count(33'(seen_count) + 33'(v));
            if (ext_end > need_end) need_end = ext_end;
            parse_state = PS_LIST_HI;
          end else if (v == '0) begin
            next_ext_header();
          end else begin
            parse_state = PS_SKIP_EXT;
          end
        end
      end
      PS_SKIP_EXT: begin
        ext_left = 16'(count_down(24'(ext_left)));
        if (ext_left == '0) next_ext_header();
      end
      PS_LIST_HI: begin
        hi_hold     = b;
        ext_left    = 16'(count_down(24'(ext_left)));
        parse_state = PS_LIST_LO;
      end
      PS_LIST_LO: begin
        ext_left  = 16'(count_down(24'(ext_left)));
        v         = {1'b0, hi_hold, b};
        // list longer than the extension is cut to it
        list_left = (v[15:0] < ext_left) ? v[15:0] : ext_left;
        next_entry_header();
      end
      PS_ENT_TYPE: begin
        sni_flag = (b == NAME_TYPE_HOST);
        step_in_list();
        parse_state = PS_ENT_LEN_HI;
      end
      PS_ENT_LEN_HI: begin
        hi_hold = b;
        step_in_list();
        parse_state = PS_ENT_LEN_LO;
      end
      PS_ENT_LEN_LO: begin
        step_in_list();
        v = {1'b0, hi_hold, b};
        if (v > list_left) begin
          mark_failed();
        end else if (sni_flag) begin
          if (v == '0) begin
            mark_failed();
          end else begin
            name_left      = v[15:0];
            name_len_total = v[15:0];
            parse_state    = PS_NAME;
          end
        end else if (v == '0) begin
          next_entry_header();
        end else begin
          name_left   = v[15:0];
          parse_state = PS_SKIP_ENT;
        end
      end
      PS_SKIP_ENT: begin
        step_in_list();
        name_left = 16'(count_down(24'(name_left)));
        if (name_left == '0) next_entry_header();
      end
      PS_NAME: begin
        nvalid    = 1'b1;
        name_left = 16'(count_down(24'(name_left)));
        if (name_left == '0) begin
          found_flag  = 1'b1;
          parse_state = PS_FOUND;
        end
      end
      default: ;
    endcase

    if (nvalid || is_last) begin
      beat             = '0;
      beat.name_byte   = nvalid ? b : '0;
      beat.name_valid  = nvalid;
      beat.done_res    = is_last;
      if (is_last) begin
        if (found_flag && seen_count >= need_end) begin
          beat.found   = 1'b1;
          beat.sni_len = name_len_total;
          names_found++;
        end
        reset_parser();
      end
      name_beats_due.push_back(beat);
    end
  endtask

  // predict on every input beat, compare every output beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_parser();
      name_beats_due.delete();
      mismatch_count = 0;
      beats_checked  = 0;
      names_found    = 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        parse_hello_byte(in_mon_i.data_byte, in_mon_i.last_byte);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (name_beats_due.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing due", beats_checked));
        end else begin
          want_beat = name_beats_due.pop_front();
          if (out_mon_i.name_byte !== want_beat.name_byte) begin
            report_mismatch($sformatf("beat %0d name_byte got %h want %h", beats_checked,
                                      out_mon_i.name_byte, want_beat.name_byte));
          end
          if (out_mon_i.name_valid !== want_beat.name_valid) begin
            report_mismatch($sformatf("beat %0d name_valid got %b want %b", beats_checked,
                                      out_mon_i.name_valid, want_beat.name_valid));
          end
          if (out_mon_i.done_res !== want_beat.done_res) begin
            report_mismatch($sformatf("beat %0d done_res got %b want %b", beats_checked,
                                      out_mon_i.done_res, want_beat.done_res));
          end
          if (out_mon_i.found !== want_beat.found) begin
            report_mismatch($sformatf("beat %0d found got %b want %b", beats_checked,
                                      out_mon_i.found, want_beat.found));
          end
          if (out_mon_i.sni_len !== want_beat.sni_len) begin
            report_mismatch($sformatf("beat %0d sni_len got %0d want %0d", beats_checked,
                                      out_mon_i.sni_len, want_beat.sni_len));
          end
        end
        beats_checked++;
      end
    end
    fail_count_o    = mismatch_count;
    pending_o       = name_beats_due.size();
    beats_checked_o = beats_checked;
    names_found_o   = names_found;
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tsni_pkg::*;

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned PHASE_BYTES  = 420;
  localparam int unsigned NUM_PHASES   = 3;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // idle percentages per phase, sender then receiver
  localparam int unsigned SEND_IDLE_PCT [NUM_PHASES] = '{30, 60, 0};
  localparam int unsigned RECV_IDLE_PCT [NUM_PHASES] = '{60, 30, 0};

  // tiny records on the header checks, {last_byte, data_byte}
  localparam logic [8:0] TINY_RECORDS [21] = '{
    9'h100,
    9'h1ff,
    {1'b0, REC_TYPE_HANDSHAKE}, 9'h004, 9'h1ff,
    {1'b0, REC_TYPE_HANDSHAKE}, {1'b0, VER_MAJOR}, 9'h001, 9'h000, 9'h030, 9'h002, 9'h100,
    {1'b0, REC_TYPE_HANDSHAKE}, {1'b0, VER_MAJOR}, 9'h003, 9'h000, 9'h040,
    {1'b0, HS_CLIENT_HELLO}, 9'h000, 9'h100,
    {1'b1, REC_TYPE_HANDSHAKE}
  };

  // kinds of generated records
  typedef enum int {
    HELLO_GOOD, HELLO_LONG_HS, HELLO_FEW_EXT, HELLO_EXT_OVERRUN, HELLO_LIST_OVERRUN,
    HELLO_ENTRY_OVERRUN, HELLO_EMPTY_NAME, HELLO_CUT, HELLO_CUT_AFTER_NAME, HELLO_NOISE,
    HELLO_MODES
  } hello_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic [7:0]  rec_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned cycle_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned records_sent  = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_checked;
  int unsigned names_found;

  tsni_in_if  in_ch ();
  tsni_out_if out_ch ();

  tls_sni_extractor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tsni_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon_i        (in_ch),
    .out_mon_i       (out_ch),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .beats_checked_o (beats_checked),
    .names_found_o   (names_found)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d result beats still due", cycle_count, pending);
    $display("Mismatches found");
    $finish;
  end

  // receiver ready, with random stalls and a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req != 0) begin
        hold_left     = hold_req - 1;
        hold_req      = 0;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one byte beat and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= is_last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic push16(input int unsigned v);
    rec_q.push_back(v[15:8]);
    rec_q.push_back(v[7:0]);
  endtask

  task automatic patch16(input int unsigned at, input int unsigned v);
    rec_q[at]   = v[15:8];
    rec_q[at+1] = v[7:0];
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) rec_q.push_back(8'($urandom_range(255)));
  endtask

  // extension of some type other than server name
  task automatic push_other_ext();
    int unsigned n;
    n = $urandom_range(4);
    push16($urandom_range(1, 16'hffff));
    push16(n);
    push_random(n);
  endtask

  // server name list entry with a short random body
  task automatic push_side_entry(input logic [7:0] kind);
    int unsigned n;
    n = $urandom_range(3);
    rec_q.push_back(kind);
    push16(n);
    push_random(n);
  endtask

  // build one record into rec_q
  task automatic build_client_hello(input hello_mode_e mode);
    int unsigned hs_len_at, body_start, ext_len_at, ext_start;
    int unsigned sni_len_at, sni_start, list_at, list_start;
    int unsigned name_len, declared, name_end, n, cut;
    logic [23:0] hs_len;
    rec_q.delete();
    if (mode == HELLO_NOISE) begin
      n = $urandom_range(1, 30);
      push_random(n);
      if ($urandom_range(1)) rec_q[0] = REC_TYPE_HANDSHAKE;
      if (n > 1 && $urandom_range(1)) rec_q[1] = VER_MAJOR;
      return;
    end

    // record and handshake headers, handshake length patched later
    rec_q.push_back(REC_TYPE_HANDSHAKE);
    rec_q.push_back(VER_MAJOR);
    rec_q.push_back(8'($urandom_range(4)));
    push16($urandom_range(16'hffff));
    rec_q.push_back(HS_CLIENT_HELLO);
    hs_len_at = rec_q.size();
    push_random(3);
    body_start = rec_q.size();
    push_random(FIXED_LEN);

    // session id, cipher suites, compression methods
    n = ($urandom_range(7) == 0) ? 32 : $urandom_range(3);
    rec_q.push_back(8'(n));
    push_random(n);
    n = ($urandom_range(7) == 0) ? $urandom_range(5, 12) : 2 * $urandom_range(2);
    push16(n);
    push_random(n);
    n = $urandom_range(2);
    rec_q.push_back(8'(n));
    push_random(n);

    ext_len_at = rec_q.size();
    push16(0);
    ext_start = rec_q.size();
    repeat ($urandom_range(2)) push_other_ext();
    name_end = rec_q.size();

    if (mode == HELLO_FEW_EXT) begin
      // block ends with too few bytes for another header
      push_random($urandom_range(3));
    end else begin
      // server name extension too short to hold a list
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(1);
        push16(EXT_SERVER_NAME);
        push16(n);
        push_random(n);
      end
      // server name extension whose list has no host name entry
      if ($urandom_range(3) == 0) begin
        push16(EXT_SERVER_NAME);
        sni_len_at = rec_q.size();
        push16(0);
        sni_start = rec_q.size();
        list_at   = rec_q.size();
        push16(0);
        list_start = rec_q.size();
        push_side_entry(8'($urandom_range(1, 255)));
        patch16(list_at, rec_q.size() - list_start);
        push_random($urandom_range(2));
        patch16(sni_len_at, rec_q.size() - sni_start);
      end

      // the server name extension with a host name
      push16(EXT_SERVER_NAME);
      sni_len_at = rec_q.size();
      push16(0);
      sni_start = rec_q.size();
      list_at   = rec_q.size();
      push16(0);
      list_start = rec_q.size();
      if ($urandom_range(2) == 0) push_side_entry(8'($urandom_range(1, 255)));
      rec_q.push_back(NAME_TYPE_HOST);
      if (mode == HELLO_EMPTY_NAME) name_len = 0;
      else if ($urandom_range(9) == 0) name_len = $urandom_range(13, 60);
      else name_len = $urandom_range(1, 12);
      declared = name_len;
      if (mode == HELLO_ENTRY_OVERRUN) declared = name_len + $urandom_range(1, 20);
      push16(declared);
      push_random(name_len);
      name_end = rec_q.size();
      if (mode == HELLO_CUT_AFTER_NAME ||
          (mode != HELLO_ENTRY_OVERRUN && $urandom_range(3) == 0)) begin
        push_side_entry(8'($urandom_range(255)));
      end
      n = rec_q.size() - list_start;
      if (mode == HELLO_LIST_OVERRUN) n = n + $urandom_range(1, 300);
      patch16(list_at, n);
      n = rec_q.size() - sni_start;
      if (mode == HELLO_EXT_OVERRUN) n = n + $urandom_range(1, 20);
      patch16(sni_len_at, n);
      if (mode != HELLO_EXT_OVERRUN) repeat ($urandom_range(2)) push_other_ext();
    end
    patch16(ext_len_at, rec_q.size() - ext_start);
    push_random($urandom_range(2));

    // declared handshake length, too long on purpose in one mode
    hs_len = 24'(rec_q.size() - body_start);
    if (mode == HELLO_LONG_HS) begin
      hs_len = ($urandom_range(3) == 0) ? 24'hffffff : hs_len + 24'($urandom_range(1, 200));
    end
    rec_q[hs_len_at]   = hs_len[23:16];
    rec_q[hs_len_at+1] = hs_len[15:8];
    rec_q[hs_len_at+2] = hs_len[7:0];

    // truncated records
    cut = rec_q.size();
    if (mode == HELLO_CUT) cut = $urandom_range(1, rec_q.size() - 1);
    if (mode == HELLO_CUT_AFTER_NAME) cut = name_end;
    while (rec_q.size() > cut) void'(rec_q.pop_back());
  endtask

  // stimulus and verdict
  initial begin
    hello_mode_e mode;
    int unsigned phase_bytes;
    int unsigned records_built;
    records_built   = 0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    rst_ni          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = SEND_IDLE_PCT[0];
    recv_idle_pct = RECV_IDLE_PCT[0];
    foreach (TINY_RECORDS[i]) begin
      send_byte(TINY_RECORDS[i][7:0], TINY_RECORDS[i][8]);
      if (TINY_RECORDS[i][8]) records_sent++;
    end

    // random records, idling pattern changes per phase
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = SEND_IDLE_PCT[ph];
      recv_idle_pct = RECV_IDLE_PCT[ph];
      if (ph == NUM_PHASES - 1) hold_req = HOLD_CYCLES;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        if (records_built < int'(HELLO_MODES)) mode = hello_mode_e'(records_built);
        else if ($urandom_range(1)) mode = HELLO_GOOD;
        else mode = hello_mode_e'($urandom_range(int'(HELLO_MODES) - 1));
        build_client_hello(mode);
        records_built++;
        foreach (rec_q[i]) send_byte(rec_q[i], i == rec_q.size() - 1);
        phase_bytes += rec_q.size();
        records_sent++;
      end
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b0;

    // drain
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d bytes in %0d records, header faults, length overruns and cut",
             bytes_sent, records_sent);
    $display("records, with idling both ways, a %0d-cycle output stall; %0d beats, %0d names",
             HOLD_CYCLES, beats_checked, names_found);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
